// ===== rtl/vertex_dedup_indexer_assert.svh =====
// Assertion macros for the vertex dedup indexer.
// Used by the top level only.
`ifndef VERTEX_DEDUP_INDEXER_ASSERT_SVH
`define VERTEX_DEDUP_INDEXER_ASSERT_SVH

// a condition implies another on the same edge
`define VDI_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// a condition implies another on the next edge
`define VDI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== rtl/vdi_pkg.sv =====
// Package for the vertex dedup indexer: widths, queue item, result and engine state types.
// No dependencies.
`timescale 1ns / 1ps
package vdi_pkg;
  localparam int TableDepth = 1024;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = IdxW + 1;
  localparam int KeyW = 256;
  localparam int OutIdxW = 10;

  typedef struct packed {
    logic            start_mesh;
    logic [KeyW-1:0] key;
  } item_t;

  typedef struct packed {
    logic [OutIdxW-1:0] vertex_index;
    logic               is_new;
    logic               overflow;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CMP, S_OUT
  } eng_state_t;
endpackage

// ===== rtl/vdi_front.sv =====
// Front end: a two-entry queue that takes input items and passes them to the back end.
// Depends on vdi_pkg.
`timescale 1ns / 1ps
module vdi_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  vdi_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_ready,
  output vdi_pkg::item_t q_item
);
  import vdi_pkg::*;

  item_t      mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign in_ready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = mem[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem[wp] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (q_valid && q_ready) rp <= ~rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end
endmodule

// ===== rtl/vdi_back.sv =====
// Back end: linear search over the key memory, insert on miss, overflow flag when full.
// Depends on vdi_pkg.
`timescale 1ns / 1ps
module vdi_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  vdi_pkg::item_t   q_item,
  output logic             out_valid,
  input  logic             out_ready,
  output vdi_pkg::result_t out_res
);
  import vdi_pkg::*;

  logic [KeyW-1:0] key_mem [TableDepth];
  logic [KeyW-1:0] rd_data;
  logic [KeyW-1:0] key;
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic [CntW-1:0] scan;
  logic [CntW-1:0] scan_next;
  logic            wr_en;
  eng_state_t      state;
  eng_state_t      state_next;
  result_t         res_next;
  logic            res_load;

  always_ff @(posedge clk) begin
    if (wr_en) key_mem[count[IdxW-1:0]] <= key;
    rd_data <= key_mem[scan[IdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      scan      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      scan  <= scan_next;
      if (res_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) key <= q_item.key;
    if (res_load) out_res <= res_next;
  end

  always_comb begin
    state_next = state;
    count_next = count;
    scan_next  = scan;
    q_ready    = 1'b0;
    wr_en      = 1'b0;
    res_load   = 1'b0;
    res_next   = '0;
    case (state)
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          if (q_item.start_mesh) count_next = '0;
          scan_next  = '0;
          state_next = S_READ;
        end
      end
      S_READ: begin
        // issue read of the scan slot, or finish on a miss
        if (scan == count) begin
          if (!out_valid || out_ready) begin
            res_load = 1'b1;
            if (count == CntW'(TableDepth)) begin
              res_next.overflow = 1'b1;
            end else begin
              res_next.vertex_index = OutIdxW'(count);
              res_next.is_new       = 1'b1;
              wr_en      = 1'b1;
              count_next = count + 1'b1;
            end
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (rd_data == key) begin
          state_next = S_OUT;
        end else begin
          scan_next  = scan + 1'b1;
          state_next = S_READ;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          res_load              = 1'b1;
          res_next.vertex_index = OutIdxW'(scan);
          state_next            = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== rtl/vertex_dedup_indexer.sv =====
// Search time grows with N, the number of stored keys compared (all of them on a miss),
// as the engine scans the key memory one slot at a time.
// The engine searches for one vertex at a time and waits while a result is held;
// a two-word queue decouples input.
// Reset (rst, synchronous) empties the table and queue; memory is not cleared.
// Top level: front queue and back search engine. Depends on vdi_pkg.
`timescale 1ns / 1ps
`include "vertex_dedup_indexer_assert.svh"
module vertex_dedup_indexer (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z
  input  logic [255:0] s_tdata,
  // start_mesh
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // vertex_index, is_new, overflow, zero fill
  output logic [15:0]  m_tdata
);
  import vdi_pkg::*;

  item_t   in_item;
  item_t   q_item;
  logic    q_valid;
  logic    q_ready;
  result_t res;

  always_comb begin
    in_item.start_mesh = s_tuser;
    in_item.key        = s_tdata;
  end

  vdi_front u_front (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .in_item,
    .q_valid, .q_ready, .q_item
  );

  vdi_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item,
    .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
  );

  assign m_tdata = {4'd0, res.overflow, res.is_new, res.vertex_index};

  `VDI_ASSERT_IMPLY(a_flags_excl, m_tvalid, !(res.is_new && res.overflow))
  `VDI_ASSERT_IMPLY(a_ovf_zero, m_tvalid && res.overflow, res.vertex_index == '0)
  `VDI_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

// ===== sim/vertex_dedup_indexer_checker.sv =====
// Checker for the vertex dedup indexer: watches both stream channels,
// predicts each result from its own table of unique keys and compares.
// Depends on vdi_pkg.
`timescale 1ns / 1ps
module vertex_dedup_indexer_checker
  import vdi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [255:0] s_tdata,
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [15:0]  m_tdata,
  output int           errors,
  output int           pending
);
  logic [KeyW-1:0] unique_keys [TableDepth];
  int              unique_cnt;
  result_t         expected_indices [$];

  // Look the key up among stored vertices; append it on a miss if there is room.
  function automatic result_t lookup_vertex(input logic start, input logic [KeyW-1:0] key);
    result_t r;
    r = '0;
    if (start) unique_cnt = 0;
    for (int i = 0; i < unique_cnt; i++) begin
      if (unique_keys[i] == key) begin
        r.vertex_index = OutIdxW'(i);
        return r;
      end
    end
    if (unique_cnt < TableDepth) begin
      unique_keys[unique_cnt] = key;
      r.vertex_index = OutIdxW'(unique_cnt);
      r.is_new = 1'b1;
      unique_cnt++;
    end else begin
      r.overflow = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    logic [9:0] got_idx;
    logic got_new, got_ovf;
    if (rst) begin
      unique_cnt = 0;
      expected_indices.delete();
    end else begin
      if (s_tvalid && s_tready)
        expected_indices = {expected_indices, lookup_vertex(s_tuser, s_tdata)};
      if (m_tvalid && m_tready) begin
        got_idx = m_tdata[9:0];
        got_new = m_tdata[10];
        got_ovf = m_tdata[11];
        if (expected_indices.size() == 0) begin
          $error("unexpected word: vertex_index %0d is_new %0b overflow %0b",
                 got_idx, got_new, got_ovf);
          errors++;
        end else begin
          want = expected_indices.pop_front();
          if (got_idx !== want.vertex_index) begin
            $error("vertex_index: expected %0d, got %0d", want.vertex_index, got_idx);
            errors++;
          end
          if (got_new !== want.is_new) begin
            $error("is_new: expected %0b, got %0b", want.is_new, got_new);
            errors++;
          end
          if (got_ovf !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, got_ovf);
            errors++;
          end
        end
      end
    end
    pending = expected_indices.size();
  end
endmodule

// ===== sim/vertex_dedup_indexer_tb.sv =====
// Top of the vertex dedup indexer testbench: clock, reset, vertex stimulus
// and result back-pressure. Depends on vdi_pkg, the block and its checker.
`timescale 1ns / 1ps
module vertex_dedup_indexer_tb;
  import vdi_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [255:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [15:0]  m_tdata;
  int           errors;
  int           pending;
  bit           quiet = 1'b0;
  bit           hold_req = 1'b0;
  bit           all_sent = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  vertex_dedup_indexer u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  vertex_dedup_indexer_checker u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending)
  );

  function automatic logic [255:0] rand_vertex();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[32*i +: 32] = $urandom;
    return v;
  endfunction

  // Offer one word, hold it until accepted, then maybe idle for a burst.
  task automatic send_vertex(input logic start, input logic [255:0] v);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= start;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    if (!quiet && $urandom_range(3) == 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(13)) @(negedge clk);
    end
  endtask

  // Result side: random ready bursts, one long hold-off on request.
  initial begin
    @(negedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end else if (quiet || $urandom_range(1)) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(14, 1)) @(negedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(14, 1)) @(negedge clk);
      end
    end
  end

  initial begin
    logic [255:0] pool [16];
    logic [255:0] v;
    int pool_n, mesh_len;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, repeats, signed zeros, NaN and a clear.
    send_vertex(1'b1, '0);
    send_vertex(1'b0, '1);
    send_vertex(1'b0, '0);
    send_vertex(1'b0, {224'h0, 32'h8000_0000});
    send_vertex(1'b0, {224'h0, 32'h7fc0_0000});
    send_vertex(1'b0, {224'h0, 32'h7fc0_0000});
    send_vertex(1'b0, {32'h8000_0000, 224'h0});
    send_vertex(1'b0, '1);
    send_vertex(1'b1, '1);
    send_vertex(1'b0, '0);
    send_vertex(1'b0, '1);

    // Random meshes: small tables, mostly repeated vertices, some clears.
    hold_req = 1'b1;
    for (int n = 0; n < 500; ) begin
      mesh_len = $urandom_range(30, 1);
      pool_n = $urandom_range(16, 1);
      for (int k = 0; k < pool_n; k++) begin
        pool[k] = rand_vertex();
        if ($urandom_range(3) == 0) pool[k][$urandom_range(255)] ^= 1'b1;
      end
      for (int k = 0; k < mesh_len && n < 500; k++, n++) begin
        if (n >= 440) quiet = 1'b1;
        v = ($urandom_range(4) == 0) ? rand_vertex() : pool[$urandom_range(pool_n - 1)];
        send_vertex(k == 0 || $urandom_range(40) == 0, v);
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    all_sent = 1'b1;
  end

  initial begin
    wait (all_sent);
    do @(posedge clk); while (pending != 0);
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
